[rtl/quadratic_root_solver_assert.svh]
// assertion macros for the quadratic root solver
// expects clk and rst in the scope where the macros are used
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/qrs_pkg.sv]
// shared types and constants of the quadratic root solver
// used by the square root cells, the divide cells and the top level
`default_nettype none
package qrs_pkg;

  localparam int CW    = 32;           // coefficient width
  localparam int FB    = 16;           // fraction bits
  localparam int DW    = 2 * CW + 1;   // discriminant width
  localparam int SW    = CW + 1;       // square root width
  localparam int NW    = CW + 2;       // numerator magnitude width
  localparam int QNW   = NW + FB;      // shifted numerator / quotient width
  localparam int RW    = CW + 1;       // divisor and remainder width
  localparam int IDXW  = 6;            // cell bit index width

  typedef enum logic [1:0] {
    KIND_TWO    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_AZERO  = 2'd3
  } kind_t;

  // square root chain element
  typedef struct packed {
    logic          valid;
    kind_t         kind;
    logic          aneg;
    logic          bneg;
    logic [CW-1:0] amag;
    logic [CW-1:0] bmag;
    logic [DW-1:0] rem;
    logic [SW-1:0] res;
  } sq_t;

  // one divide lane
  typedef struct packed {
    logic           neg;
    logic [QNW-1:0] num;
    logic [RW-1:0]  rem;
    logic [CW-1:0]  quo;
    logic           ovf;
  } dv_lane_t;

  // divide chain element, two lanes sharing the divisor
  typedef struct packed {
    logic          valid;
    kind_t         kind;
    logic [RW-1:0] den;
    dv_lane_t      lo;
    dv_lane_t      hi;
  } dv_t;

endpackage
`default_nettype wire

[rtl/quadratic_root_solver.sv]
// top level of the quadratic root solver: front end, cell chains, output stage
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the assertion macros
//
// usage:
//   s channel takes one request per cycle: coef_a, coef_b, coef_c (Q16.16).
//   m channel returns one result per request, in request order: two roots
//   in tdata, root kind and saturation flag in tuser.
//   a request passes from acceptance to m_tvalid through 88 registers:
//   one input register, one multiply stage, one discriminant stage, 33 square
//   root cells (one root bit each), one numerator stage, 50 divide cells (one
//   quotient bit each, both roots side by side) and the output register.
//   throughput is one request per cycle while m_tready is high.
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; it rises again in the cycle the result is taken.
//   reset empties the pipeline; no result is pending afterwards.
`default_nettype none
`include "quadratic_root_solver_assert.svh"
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [95:0]   s_tdata,   // coef_a, coef_b, coef_c
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [63:0]        m_tdata,   // root_first, root_second
  output logic [2:0]         m_tuser    // root_kind, saturated
);

  localparam int SCELLS = SW;
  localparam int DCELLS = QNW;

  logic advance;

  // input stage
  logic          p1_valid;
  logic          p1_aneg, p1_bneg, p1_cneg;
  logic [CW-1:0] p1_amag, p1_bmag, p1_cmag;

  // product stage
  logic            p2_valid;
  logic            p2_aneg, p2_bneg, p2_azero, p2_acpos;
  logic [CW-1:0]   p2_amag, p2_bmag;
  logic [2*CW-1:0] p2_bb, p2_ac;

  sq_t sq_pipe [SCELLS+1];
  dv_t dv_pipe [DCELLS+1];
  sq_t sq_head;
  dv_t dv_head;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  function automatic logic [CW-1:0] mag_of(logic [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= s_tvalid;
    end
    if (advance) begin
      p1_aneg <= s_tdata[CW-1];
      p1_bneg <= s_tdata[2*CW-1];
      p1_cneg <= s_tdata[3*CW-1];
      p1_amag <= mag_of(s_tdata[CW-1:0]);
      p1_bmag <= mag_of(s_tdata[2*CW-1:CW]);
      p1_cmag <= mag_of(s_tdata[3*CW-1:2*CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (advance) begin
      p2_valid <= p1_valid;
    end
    if (advance) begin
      p2_aneg  <= p1_aneg;
      p2_bneg  <= p1_bneg;
      p2_amag  <= p1_amag;
      p2_bmag  <= p1_bmag;
      p2_azero <= (p1_amag == '0);
      p2_acpos <= (p1_aneg == p1_cneg) && (p1_cmag != '0);
      p2_bb    <= p1_bmag * p1_bmag;
      p2_ac    <= p1_amag * p1_cmag;
    end
  end

  // discriminant and classification
  always_comb begin
    logic [DW-1:0] bb_ext;
    logic [DW-1:0] ac4;
    bb_ext        = {1'b0, p2_bb};
    ac4           = {p2_ac[DW-3:0], 2'b00};
    sq_head       = '0;
    sq_head.valid = p2_valid;
    sq_head.aneg  = p2_aneg;
    sq_head.bneg  = p2_bneg;
    sq_head.amag  = p2_amag;
    sq_head.bmag  = p2_bmag;
    sq_head.kind  = KIND_TWO;
    if (p2_azero) begin
      sq_head.kind = KIND_AZERO;
    end else if (!p2_acpos) begin
      sq_head.rem = bb_ext + ac4;
    end else if (bb_ext < ac4) begin
      sq_head.kind = KIND_NONE;
    end else begin
      sq_head.rem = bb_ext - ac4;
    end
    if ((sq_head.kind == KIND_TWO) && (sq_head.rem == '0)) begin
      sq_head.kind = KIND_DOUBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pipe[0].valid <= 1'b0;
    end else if (advance) begin
      sq_pipe[0] <= sq_head;
    end
  end

  for (genvar j = 0; j < SCELLS; j++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .idx  (IDXW'(SCELLS - 1 - j)),
      .din  (sq_pipe[j]),
      .dout (sq_pipe[j+1])
    );
  end

  // numerators -sqrt-b and sqrt-b, split into sign and magnitude
  always_comb begin
    sq_t           t;
    logic [NW:0]   bval, s_ext, n_lo, n_hi;
    logic [NW-1:0] m_lo, m_hi;
    t     = sq_pipe[SCELLS];
    bval  = t.bneg ? -{{(NW+1-CW){1'b0}}, t.bmag} : {{(NW+1-CW){1'b0}}, t.bmag};
    s_ext = {{(NW+1-SW){1'b0}}, t.res};
    n_lo  = -s_ext - bval;
    n_hi  = s_ext - bval;
    m_lo  = n_lo[NW] ? NW'(-n_lo) : n_lo[NW-1:0];
    m_hi  = n_hi[NW] ? NW'(-n_hi) : n_hi[NW-1:0];
    dv_head        = '0;
    dv_head.valid  = t.valid;
    dv_head.kind   = t.kind;
    dv_head.den    = {t.amag, 1'b0};
    dv_head.lo.neg = n_lo[NW] ^ t.aneg;
    dv_head.hi.neg = n_hi[NW] ^ t.aneg;
    dv_head.lo.num = {m_lo, {FB{1'b0}}};
    dv_head.hi.num = {m_hi, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_pipe[0].valid <= 1'b0;
    end else if (advance) begin
      dv_pipe[0] <= dv_head;
    end
  end

  for (genvar j = 0; j < DCELLS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .idx  (IDXW'(DCELLS - 1 - j)),
      .din  (dv_pipe[j]),
      .dout (dv_pipe[j+1])
    );
  end

  // clamp, apply sign, blank the no-root cases
  function automatic logic [CW:0] finish(dv_lane_t l);
    logic [CW-1:0] limit, val;
    logic          over;
    limit = l.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    over  = l.ovf || (l.quo > limit);
    val   = over ? limit : l.quo;
    return {over, (l.neg ? CW'(-val) : val)};
  endfunction

  logic [CW:0]   fin_lo, fin_hi;
  logic          has_roots;
  logic [63:0]   m_tdata_next;
  logic [2:0]    m_tuser_next;

  always_comb begin
    fin_lo    = finish(dv_pipe[DCELLS].lo);
    fin_hi    = finish(dv_pipe[DCELLS].hi);
    has_roots = (dv_pipe[DCELLS].kind == KIND_TWO) || (dv_pipe[DCELLS].kind == KIND_DOUBLE);
    if (has_roots) begin
      m_tdata_next = {fin_hi[CW-1:0], fin_lo[CW-1:0]};
      m_tuser_next = {fin_lo[CW] | fin_hi[CW], dv_pipe[DCELLS].kind};
    end else begin
      m_tdata_next = '0;
      m_tuser_next = {1'b0, dv_pipe[DCELLS].kind};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dv_pipe[DCELLS].valid;
    end
    if (advance) begin
      m_tdata <= m_tdata_next;
      m_tuser <= m_tuser_next;
    end
  end

  `QRS_ASSERT_IMPL(a_stall_only_on_wait, !s_tready, m_tvalid && !m_tready, "stall without waiting result")
  `QRS_ASSERT_IMPL(a_blank_no_root, m_tvalid && (m_tuser[1:0] == KIND_NONE || m_tuser[1:0] == KIND_AZERO), m_tdata == '0 && !m_tuser[2], "no-root result not blank")
  `QRS_ASSERT_IMPL(a_double_equal, m_tvalid && m_tuser[1:0] == KIND_DOUBLE, m_tdata[31:0] == m_tdata[63:32], "double root fields differ")
  `QRS_ASSERT_IMPL(a_sat_at_limit, m_tvalid && m_tuser[2], m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 || m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000, "saturated without clamped root")
  `QRS_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser), "result changed under stall")

endmodule
`default_nettype wire

[rtl/qrs_sqrt_cell.sv]
// one bit of the pipelined integer square root (remainder form)
// depends on qrs_pkg
`default_nettype none
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [IDXW-1:0] idx,
  input  wire sq_t             din,
  output sq_t                  dout
);

  localparam int TW = DW + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_ext;
  sq_t           dout_next;

  always_comb begin
    // (cand^2 - res^2) = res * 2^(k+1) + 4^k
    trial   = ({{(TW-SW){1'b0}}, din.res} << ({1'b0, idx} + 7'd1))
            | ({{(TW-1){1'b0}}, 1'b1} << {idx, 1'b0});
    rem_ext = {2'b00, din.rem};
    dout_next = din;
    if (rem_ext >= trial) begin
      dout_next.rem = DW'(rem_ext - trial);
      dout_next.res = din.res | (SW'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

[rtl/qrs_div_cell.sv]
// one quotient bit of the pipelined restoring divider, two lanes
// depends on qrs_pkg
`default_nettype none
module qrs_div_cell
  import qrs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [IDXW-1:0] idx,
  input  wire dv_t             din,
  output dv_t                  dout
);

  dv_t dout_next;

  function automatic dv_lane_t lane_step(dv_lane_t l, logic [RW-1:0] den,
                                         logic [IDXW-1:0] k);
    logic [RW:0] part;
    dv_lane_t    r;
    r    = l;
    part = {l.rem, l.num[k]};
    if (part >= {1'b0, den}) begin
      r.rem = RW'(part - {1'b0, den});
      // bits above the result width only mark overflow
      if (k >= IDXW'(CW)) begin
        r.ovf = 1'b1;
      end else begin
        r.quo = l.quo | (CW'(1) << k);
      end
    end else begin
      r.rem = RW'(part);
    end
    return r;
  endfunction

  always_comb begin
    dout_next    = din;
    dout_next.lo = lane_step(din.lo, din.den, idx);
    dout_next.hi = lane_step(din.hi, din.den, idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

[tb/quadratic_root_solver_test.sv]
// self-checking bench for quadratic_root_solver: directed rows, then random coefficient sets
// uses qrs_pkg for the root kind enum; roots are predicted locally with wide integer math
`default_nettype none
module quadratic_root_solver_test;
  import qrs_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] first;
    logic [31:0] second;
    logic        sat;
  } roots_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        typed;
    roots_t      want;
  } row_t;

  localparam logic [31:0] MAXV  = 32'h7fffffff;
  localparam logic [31:0] MINV  = 32'h80000000;
  localparam logic [31:0] ONE   = 32'h00010000;
  localparam logic [31:0] MONE  = 32'hffff0000;
  localparam logic [31:0] TWO   = 32'h00020000;
  localparam logic [31:0] MTWO  = 32'hfffe0000;
  localparam int          NROWS = 16;
  localparam int          STALL_LIMIT = 4000;

  localparam row_t DIR_ROWS [NROWS] = '{
    '{32'd0, 32'd0, 32'd0, 1'b1, '{KIND_AZERO, 32'd0, 32'd0, 1'b0}},
    '{32'd0, MAXV,  MINV,  1'b1, '{KIND_AZERO, 32'd0, 32'd0, 1'b0}},
    '{ONE,   32'd0, ONE,   1'b1, '{KIND_NONE, 32'd0, 32'd0, 1'b0}},
    '{ONE,   32'd0, MONE,  1'b1, '{KIND_TWO, MONE, ONE, 1'b0}},
    '{ONE,   MTWO,  ONE,   1'b1, '{KIND_DOUBLE, ONE, ONE, 1'b0}},
    '{ONE,   32'd0, 32'd0, 1'b1, '{KIND_DOUBLE, 32'd0, 32'd0, 1'b0}},
    '{MONE,  32'd0, ONE,   1'b0, '0},
    '{32'd1, 32'd0, MINV,  1'b0, '0},
    '{MAXV,  MAXV,  MAXV,  1'b0, '0},
    '{MINV,  MINV,  MINV,  1'b0, '0},
    '{MAXV,  MINV,  MAXV,  1'b0, '0},
    '{MINV,  MAXV,  MINV,  1'b0, '0},
    '{32'd1, 32'd1, 32'd0, 1'b0, '0},
    '{32'hffffffff, MAXV, MAXV, 1'b0, '0},
    '{32'd1, MINV,  32'd1, 1'b0, '0},
    '{TWO,   MAXV,  MINV,  1'b0, '0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;

  roots_t pending_roots[$];
  row_t   typed_rows[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     idle_cycles = 0;
  bit     hold_req = 1'b0;
  bit     quiet = 1'b0;

  quadratic_root_solver u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // (num << 16) / (2a), truncated toward zero, clamped to the Q16.16 range
  function automatic logic [31:0] divide_root(longint num, logic aneg, logic [31:0] amag,
                                              inout bit sat);
    logic [127:0] nmag, q, lim;
    logic neg;
    nmag = (num < 0) ? 128'(-num) : 128'(num);
    neg  = (num < 0) != aneg;
    q    = (nmag << 16) / (128'(amag) << 1);
    lim  = neg ? 128'h80000000 : 128'h7fffffff;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0]  am, bm, cm;
    logic [66:0]  bb, ac4, d;
    logic [63:0]  s, cand;
    longint       bv;
    bit           sat;
    roots_t       r;
    sat = 1'b0;
    r   = '{KIND_TWO, 32'd0, 32'd0, 1'b0};
    am  = a[31] ? -a : a;
    bm  = b[31] ? -b : b;
    cm  = c[31] ? -c : c;
    if (am == 0) begin
      r.kind = KIND_AZERO;
      return r;
    end
    bb  = 67'(bm) * 67'(bm);
    ac4 = (67'(am) * 67'(cm)) << 2;
    bv  = b[31] ? -longint'(bm) : longint'(bm);
    if (a[31] == c[31] && cm != 0) begin
      if (bb < ac4) begin
        r.kind = KIND_NONE;
        return r;
      end
      d = bb - ac4;
    end else begin
      d = bb + ac4;
    end
    if (d == 0) begin
      r.kind   = KIND_DOUBLE;
      r.first  = divide_root(-bv, a[31], am, sat);
      r.second = r.first;
    end else begin
      s = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = s | (64'd1 << i);
        if (128'(cand) * 128'(cand) <= 128'(d)) s = cand;
      end
      r.first  = divide_root(-longint'(s) - bv, a[31], am, sat);
      r.second = divide_root(longint'(s) - bv, a[31], am, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  // request accept and result compare
  always @(posedge clk) begin
    roots_t want, got;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (s_tvalid && s_tready)
        pending_roots.push_back(solve_quadratic(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]));
      if (m_tvalid && m_tready) begin
        got = '{kind_t'(m_tuser[1:0]), m_tdata[31:0], m_tdata[63:32], m_tuser[2]};
        results_seen++;
        if (pending_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_roots.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random short stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic random_request;
    logic [31:0] a, b, c;
    int k, m, n;
    case ($urandom_range(0, 5))
      0: begin
        a = $urandom; b = $urandom; c = $urandom;
      end
      1: begin
        a = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
        b = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
        c = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      end
      2: begin
        // well-formed: integer roots m and n scaled by k
        k = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
        m = int'($urandom_range(0, 40)) - 20;
        n = int'($urandom_range(0, 40)) - 20;
        a = 32'(k) << 16;
        b = 32'(-k * (m + n)) << 16;
        c = 32'(k * m * n) << 16;
      end
      3: begin
        // double root at m
        k = $urandom_range(1, 100) * ($urandom_range(0, 1) ? 1 : -1);
        m = int'($urandom_range(0, 200)) - 100;
        a = 32'(k);
        b = 32'(-2 * k * m);
        c = 32'(k * m * m);
      end
      4: begin
        a = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        b = $urandom; c = 32'd0;
      end
      default: begin
        a = $urandom_range(0, 1) ? MAXV : MINV;
        b = $urandom; c = $urandom_range(0, 1) ? MINV : 32'd1;
      end
    endcase
    send_request(a, b, c);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows; typed expectations are checked on top of the predictor
    for (int i = 0; i < NROWS; i++) begin
      if (DIR_ROWS[i].typed &&
          solve_quadratic(DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].c) != DIR_ROWS[i].want) begin
        mismatches++;
        $display("directed row %0d: expected %p", i, DIR_ROWS[i].want);
      end
      send_request(DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].c);
    end
    wait_drained();

    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) random_request();
    wait_drained();
    for (int i = 0; i < 200; i++) random_request();
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) random_request();
    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d directed and 500 random coefficient sets, %0d results compared",
             NROWS, results_seen);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_roots.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
